@@ hdl/utf16t_pkg.sv @@
// Shared types, constants and encode helpers of the UTF-16 transcoder.
package utf16t_pkg;

	localparam int CNT_W = 17;
	localparam int CP_W = 21;
	localparam int UNIT_W = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [CNT_W-1:0] MAX_OUT_UNITS = 17'h10000;

	// output encodings
	localparam logic [1:0] MODE_UTF8 = 2'd0;
	localparam logic [1:0] MODE_UTF32 = 2'd1;
	localparam logic [1:0] MODE_ASCII = 2'd2;

	// result status codes
	localparam logic [2:0] ST_DATA = 3'd0;
	localparam logic [2:0] ST_END = 3'd1;
	localparam logic [2:0] ST_INCOMPLETE = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_LIMIT = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_OUT_MODE = 2'd0;
	localparam logic [1:0] CFG_OUT_LIMIT = 2'd1;
	localparam logic [1:0] CFG_REPL_CHAR = 2'd2;

	typedef struct packed {
		logic [1:0] out_mode;
		logic [CNT_W-1:0] out_limit;
		logic [6:0] replacement_char;
	} cfg_t;

	// Work handed from front to back: a run of data units, then an optional status.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [2:0] n_data;
		logic [CNT_W-1:0] base_cnt;
		logic tail_valid;
		logic [2:0] tail_status;
		logic [CNT_W-1:0] tail_cnt;
	} job_t;

	function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) n = 3'd1;
		else if (cp < 21'h800) n = 3'd2;
		else if (cp < 21'h10000) n = 3'd3;
		else n = 3'd4;
		return n;
	endfunction

	// Byte idx of the len-byte UTF-8 sequence for cp.
	function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
			input logic [2:0] len, input logic [1:0] idx);
		logic [1:0] from_end;
		logic [5:0] chunk;
		logic [7:0] b;
		from_end = len[1:0] - 2'd1 - idx;
		unique case (from_end)
			2'd0: chunk = cp[5:0];
			2'd1: chunk = cp[11:6];
			2'd2: chunk = cp[17:12];
			default: chunk = {3'b000, cp[20:18]};
		endcase
		if (idx == 2'd0) begin
			unique case (len)
				3'd2: b = {3'b110, cp[10:6]};
				3'd3: b = {4'b1110, cp[15:12]};
				3'd4: b = {5'b11110, cp[20:18]};
				default: b = {1'b0, cp[6:0]};
			endcase
		end else begin
			b = {2'b10, chunk};
		end
		return b;
	endfunction

endpackage

@@ hdl/utf16_transcoder_core.sv @@
// Top level of the UTF-16 to UTF-8 / UTF-32 / ASCII transcoder.
// The block takes one UTF-16 code unit per transfer and gives one result per cycle while out_stall
// is low. A unit yields zero to five results (up to four UTF-8 bytes plus an end-of-string
// status), so the result channel sets the pace: a held high surrogate or an ignored unit
// gives no result at all. The front end classifies each unit in the cycle it is accepted and
// hands a job to a two-entry queue; the back end expands the job into the output register,
// so a result is registered first in the queue and then in the output register, and input
// transfers go on while earlier results wait. The configuration port is always ready; write
// it only while the block is idle.
module utf16_transcoder_core import utf16t_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [CNT_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [UNIT_W-1:0] code_unit,
	input logic last_unit,
	output logic out_valid,
	input logic out_stall,
	output logic [CP_W-1:0] out_unit,
	output logic [2:0] status,
	output logic [CNT_W-1:0] out_count,
	output logic last_result
);

	cfg_t cfg_q;
	logic push, pop, empty, full;
	job_t push_job, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_mode <= MODE_UTF8;
			cfg_q.out_limit <= MAX_OUT_UNITS;
			cfg_q.replacement_char <= 7'd63;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OUT_MODE: cfg_q.out_mode <= cfg_data[1:0];
				CFG_OUT_LIMIT: cfg_q.out_limit <= cfg_data;
				CFG_REPL_CHAR: cfg_q.replacement_char <= cfg_data[6:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	utf16t_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.last_unit(last_unit),
		.q_full(full),
		.push(push),
		.job(push_job)
	);

	utf16t_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	utf16t_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_unit(out_unit),
		.status(status),
		.out_count(out_count),
		.last_result(last_result)
	);

endmodule

@@ hdl/utf16t_front.sv @@
// Front end: accepts code units, pairs surrogates, checks the limit, issues jobs.
module utf16t_front import utf16t_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input logic [UNIT_W-1:0] code_unit,
	input logic last_unit,
	input logic q_full,
	output logic push,
	output job_t job
);

	logic [9:0] pending_high_q, pending_high_d;
	logic have_pending_q, have_pending_d;
	logic [CNT_W-1:0] written_q, written_d;
	logic stopped_q, stopped_d;

	logic accept;
	logic is_high, is_low;
	logic [CP_W-1:0] cp;
	logic [2:0] len;
	logic [CNT_W-1:0] limit;
	logic [CNT_W:0] need;
	logic fits;
	logic do_encode;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	assign is_high = code_unit[15:10] == 6'b110110;
	assign is_low = code_unit[15:10] == 6'b110111;

	assign cp = have_pending_q
		? 21'h10000 + {1'b0, pending_high_q, code_unit[9:0]}
		: {5'b00000, code_unit};
	assign len = (cfg.out_mode == MODE_UTF32 || cfg.out_mode == MODE_ASCII)
		? 3'd1 : utf8_len(cp);
	assign limit = (cfg.out_limit > MAX_OUT_UNITS) ? MAX_OUT_UNITS : cfg.out_limit;
	assign need = {1'b0, written_q} + {{(CNT_W - 2){1'b0}}, len};
	assign fits = need <= {1'b0, limit};

	always_comb begin
		pending_high_d = pending_high_q;
		have_pending_d = have_pending_q;
		written_d = written_q;
		stopped_d = stopped_q;
		push = 1'b0;
		do_encode = 1'b0;
		job = '0;
		job.cp = cp;
		if (accept) begin
			priority if (stopped_q) begin
				push = 1'b0;
			end else if (have_pending_q) begin
				if (!is_low) begin
					push = 1'b1;
					job.tail_valid = 1'b1;
					job.tail_status = ST_INVALID;
					stopped_d = 1'b1;
				end else begin
					have_pending_d = 1'b0;
					pending_high_d = '0;
					do_encode = 1'b1;
				end
			end else if (is_high) begin
				if (last_unit) begin
					push = 1'b1;
					job.tail_valid = 1'b1;
					job.tail_status = ST_INCOMPLETE;
					stopped_d = 1'b1;
				end else begin
					pending_high_d = code_unit[9:0];
					have_pending_d = 1'b1;
				end
			end else if (is_low) begin
				push = 1'b1;
				job.tail_valid = 1'b1;
				job.tail_status = ST_INVALID;
				stopped_d = 1'b1;
			end else if (code_unit == '0) begin
				push = 1'b1;
				job.tail_valid = 1'b1;
				job.tail_status = ST_END;
				job.tail_cnt = written_q;
				stopped_d = 1'b1;
			end else begin
				do_encode = 1'b1;
			end

			if (do_encode) begin
				push = 1'b1;
				if (!fits) begin
					job.tail_valid = 1'b1;
					job.tail_status = ST_LIMIT;
					job.tail_cnt = written_q;
					stopped_d = 1'b1;
				end else begin
					job.n_data = len;
					job.base_cnt = written_q;
					written_d = need[CNT_W-1:0];
					job.tail_valid = last_unit;
					job.tail_status = ST_END;
					job.tail_cnt = need[CNT_W-1:0];
				end
			end

			// a last unit always starts a fresh string
			if (last_unit) begin
				pending_high_d = '0;
				have_pending_d = 1'b0;
				written_d = '0;
				stopped_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_high_q <= '0;
			have_pending_q <= 1'b0;
			written_q <= '0;
			stopped_q <= 1'b0;
		end else begin
			pending_high_q <= pending_high_d;
			have_pending_q <= have_pending_d;
			written_q <= written_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

@@ hdl/utf16t_queue.sv @@
// Short job queue between the front and back ends.
module utf16t_queue import utf16t_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input job_t push_job,
	input logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	job_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign empty = count_q == '0;
	assign full = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/utf16t_back.sv @@
// Back end: expands jobs into registered results, one per cycle while not stalled.
module utf16t_back import utf16t_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input job_t head,
	input logic empty,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [CP_W-1:0] out_unit,
	output logic [2:0] status,
	output logic [CNT_W-1:0] out_count,
	output logic last_result
);

	logic valid_q;
	logic [CP_W-1:0] unit_q;
	logic [2:0] status_q;
	logic [CNT_W-1:0] count_q;
	logic last_q;
	logic [2:0] idx_q;

	logic load, take;
	logic [2:0] total;
	logic is_data, is_last;
	logic [CP_W-1:0] data_unit;
	logic [CNT_W-1:0] data_cnt;

	assign load = !valid_q || !out_stall;
	assign take = load && !empty;
	assign total = head.n_data + {2'b00, head.tail_valid};
	assign is_data = idx_q < head.n_data;
	assign is_last = (idx_q + 3'd1) == total;
	assign pop = take && is_last;

	always_comb begin
		unique case (cfg.out_mode)
			MODE_UTF32: data_unit = head.cp;
			MODE_ASCII: data_unit = (head.cp <= 21'd127) ? head.cp
				: {14'b0, cfg.replacement_char};
			default: data_unit = {13'b0, utf8_byte(head.cp, head.n_data, idx_q[1:0])};
		endcase
	end
	assign data_cnt = head.base_cnt + {{(CNT_W - 3){1'b0}}, idx_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (take) begin
			unit_q <= is_data ? data_unit : '0;
			status_q <= is_data ? ST_DATA : head.tail_status;
			count_q <= is_data ? data_cnt : head.tail_cnt;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_q <= !empty;
			end
			if (take) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_unit = unit_q;
	assign status = status_q;
	assign out_count = count_q;
	assign last_result = last_q;

	// every job queued has at least one result, and the index stays inside it
	assert property (@(posedge clk) disable iff (!arst_n) !empty |-> idx_q < total)
		else $error("result index outside job");

	// a job leaves the queue exactly when its last result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (valid_q && last_q))
		else $error("job popped without a last result");

	// data results carry no status and status results carry no unit
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q != ST_DATA |-> unit_q == '0)
		else $error("status result with nonzero unit");

	// mid-job results are never marked last
	assert property (@(posedge clk) disable iff (!arst_n)
		take && !is_last |=> !last_q)
		else $error("last flag on inner result");

endmodule
